// ===== sv/ensb_pkg.sv =====
// shared types, constants and codes of the event number sync builder
package ensb_pkg;

	// default sizes
	localparam int NUM_SOURCES_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// fixed field widths
	localparam int SRC_ID_W = 3;
	localparam int EVN_W    = 32;
	localparam int HANDLE_W = 32;
	localparam int CFG_W    = 8;

	// register port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// word index of the source enable register (paddr[2])
	localparam logic REG_ENABLED_SOURCES = 1'b0;

	typedef enum logic {
		FUNC_PUSH      = 1'b0,
		FUNC_START_RUN = 1'b1
	} func_t;

	typedef enum logic {
		STATUS_BUILT   = 1'b0,
		STATUS_DROPPED = 1'b1
	} status_t;

	typedef struct packed {
		func_t               func;
		logic [SRC_ID_W-1:0] source_id;
		logic [EVN_W-1:0]    event_number;
		logic [HANDLE_W-1:0] payload_handle;
	} ensb_req_t;

	typedef struct packed {
		status_t             status;
		logic [SRC_ID_W-1:0] out_source;
		logic [EVN_W-1:0]    out_event_number;
		logic [HANDLE_W-1:0] out_payload;
		logic                mismatch;
		logic                last;
	} ensb_res_t;

	// register file to core
	typedef struct packed {
		logic             wr;
		logic [CFG_W-1:0] wdata;
		logic [CFG_W-1:0] enabled;
	} ensb_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CMP_RD,
		ST_CMP_EV,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

endpackage

// ===== sv/ensb_if.sv =====
// valid/ready channel interfaces for requests and results
interface ensb_req_if;
	import ensb_pkg::*;
	logic      valid;
	logic      ready;
	ensb_req_t req;

	modport source (output valid, output req, input ready);
	modport sink (input valid, input req, output ready);
endinterface

interface ensb_res_if;
	import ensb_pkg::*;
	logic      valid;
	logic      ready;
	ensb_res_t res;

	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface

// ===== sv/ensb_ram.sv =====
// generic single write, single read ram with registered read data
module ensb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/ensb_cfg.sv =====
// apb register block holding the source enable mask
module ensb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ensb_pkg::APB_AW-1:0]   paddr,
	input  logic [ensb_pkg::APB_DW-1:0]   pwdata,
	output logic [ensb_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output ensb_pkg::ensb_cfg_t           cfg
);
	import ensb_pkg::*;

	logic [CFG_W-1:0] enabled_q;
	logic             reg_hit;
	logic             wr_en;

	assign reg_hit = (paddr[2] == REG_ENABLED_SOURCES);
	assign wr_en   = psel && penable && pwrite && reg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '0;
		end else if (wr_en) begin
			enabled_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready      = 1'b1;
	assign prdata      = reg_hit ? APB_DW'(enabled_q) : '0;
	assign cfg.wr      = wr_en;
	assign cfg.wdata   = pwdata[CFG_W-1:0];
	assign cfg.enabled = enabled_q;
endmodule

// ===== sv/event_number_sync_builder_core.sv =====
// event number sync builder: per source fragment queues and a sequenced builder
//
// usage
//   req_ch carries push and start run requests; res_ch returns results.
//   a push goes into the queue of its source. once every enabled queue holds
//   a fragment, the heads are popped in ascending source order and returned
//   one result each, the highest enabled source marked last, all of them
//   flagged mismatch if any head event number differs from that of the lowest enabled source.
//   a push for a disabled or out of range source, or into a full queue, is
//   dropped and returned as one result with status dropped.
//   start run empties every queue and returns nothing.
//   the apb port holds the source enable mask at address 0; a write empties
//   the queues of sources whose bit is clear in the new mask.
// timing
//   a drop or start run leaves the sequencer idle; a push passes a check state
//   and then returns to idle or starts a build. a build adds a compare pass and
//   an emit pass over every source index, through the one ram read port and
//   one comparator. req_ch.ready is low while a build runs, and also while
//   a result waits.
// reset and stall
//   reset empties all queues and clears the mask. a stalled result holds in
//   the output register and the sequencer waits before reading the next head.
module event_number_sync_builder_core #(
	parameter int NUM_SOURCES  = ensb_pkg::NUM_SOURCES_DEF,
	parameter int QUEUE_DEPTH  = ensb_pkg::QUEUE_DEPTH_DEF,
	parameter int PAYLOAD_BITS = ensb_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ensb_req_if.sink                    req_ch,
	ensb_res_if.source                  res_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ensb_pkg::APB_AW-1:0] paddr,
	input  logic [ensb_pkg::APB_DW-1:0] pwdata,
	output logic [ensb_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import ensb_pkg::*;

	// source index, queue pointer and fill count widths
	localparam int SRC_W     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int SLOTS     = 1 << SRC_W;
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int RAM_DEPTH = SLOTS << PTR_W;
	localparam int RAM_AW    = SRC_W + PTR_W;
	localparam int RAM_W     = EVN_W + PAYLOAD_BITS;
	// payload bits that survive both the store and the result field
	localparam int KEEP_W    = (PAYLOAD_BITS < HANDLE_W) ? PAYLOAD_BITS : HANDLE_W;

	ensb_cfg_t cfg;

	state_t state_q, state_d;

	logic [SRC_W-1:0] s_q;
	logic [PTR_W-1:0] rptr_q [SLOTS];
	logic [PTR_W-1:0] wptr_q [SLOTS];
	logic [CNT_W-1:0] cnt_q  [SLOTS];

	logic [EVN_W-1:0] ref_evn_q;
	logic             have_ref_q;
	logic             mm_q;

	ensb_res_t res_q;
	logic      res_valid_q;

	// combinational
	logic [SLOTS-1:0]        mask;
	logic [SRC_W-1:0]        sel_idx;
	logic [PTR_W-1:0]        sel_rptr;
	logic [PTR_W-1:0]        sel_wptr;
	logic [CNT_W-1:0]        sel_cnt;
	logic [PTR_W-1:0]        rptr_nxt;
	logic [PTR_W-1:0]        wptr_nxt;
	logic                    in_range;
	logic                    drop;
	logic                    req_fire;
	logic                    push_ok;
	logic                    drop_fire;
	logic                    run_fire;
	logic                    out_free;
	logic                    s_en;
	logic                    s_last;
	logic                    last_src;
	logic                    all_ready;
	logic                    in_ready;
	logic                    ram_re;
	logic                    s_clr;
	logic                    s_inc;
	logic                    do_cmp;
	logic                    do_pop;
	logic [RAM_W-1:0]        ram_wdata;
	logic [RAM_W-1:0]        ram_rdata;
	logic [PAYLOAD_BITS-1:0] pay_store;
	logic [HANDLE_W-1:0]     pay_drop;
	logic [HANDLE_W-1:0]     pay_out;
	logic [EVN_W-1:0]        head_evn;

	ensb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// only the low NUM_SOURCES mask bits take effect
	assign mask = SLOTS'(cfg.enabled[NUM_SOURCES-1:0]);

	// one shared read of the pointer and count registers: the request's
	// source while idle, the scan index while building
	assign sel_idx  = (state_q == ST_IDLE) ? req_ch.req.source_id[SRC_W-1:0] : s_q;
	assign sel_rptr = rptr_q[sel_idx];
	assign sel_wptr = wptr_q[sel_idx];
	assign sel_cnt  = cnt_q[sel_idx];
	assign rptr_nxt = (sel_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_rptr + 1'b1;
	assign wptr_nxt = (sel_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_wptr + 1'b1;

	assign in_range = ({1'b0, req_ch.req.source_id} < (SRC_ID_W + 1)'(NUM_SOURCES));
	assign drop     = !in_range || !mask[sel_idx] || (sel_cnt == CNT_W'(QUEUE_DEPTH));

	assign out_free  = !res_valid_q || res_ch.ready;
	assign req_fire  = req_ch.valid && in_ready;
	assign push_ok   = req_fire && (req_ch.req.func == FUNC_PUSH) && !drop;
	assign drop_fire = req_fire && (req_ch.req.func == FUNC_PUSH) && drop;
	assign run_fire  = req_fire && (req_ch.req.func == FUNC_START_RUN);

	assign s_en     = mask[s_q];
	assign s_last   = (s_q == SRC_W'(NUM_SOURCES - 1));
	// no enabled source above the scan index
	assign last_src = ((mask >> s_q) >> 1) == '0;

	always_comb begin
		all_ready = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			if (mask[i] && (cnt_q[i] == '0)) begin
				all_ready = 1'b0;
			end
		end
	end

	// payload kept to PAYLOAD_BITS on the way in, widened to the field on the way out
	always_comb begin
		pay_store = '0;
		pay_store[KEEP_W-1:0] = req_ch.req.payload_handle[KEEP_W-1:0];
		pay_drop = '0;
		pay_drop[KEEP_W-1:0] = req_ch.req.payload_handle[KEEP_W-1:0];
		pay_out = '0;
		pay_out[KEEP_W-1:0] = ram_rdata[KEEP_W-1:0];
	end

	assign ram_wdata = {req_ch.req.event_number, pay_store};
	assign head_evn  = ram_rdata[RAM_W-1 -: EVN_W];

	ensb_ram #(
		.WIDTH (RAM_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr ({req_ch.req.source_id[SRC_W-1:0], sel_wptr}),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr ({s_q, sel_rptr}),
		.rdata (ram_rdata)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (push_ok) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = all_ready ? ST_CMP_RD : ST_IDLE;
			end
			ST_CMP_RD: begin
				if (s_en) begin
					state_d = ST_CMP_EV;
				end else if (s_last) begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_CMP_EV: begin
				state_d = s_last ? ST_EMIT_RD : ST_CMP_RD;
			end
			ST_EMIT_RD: begin
				if (s_en) begin
					if (out_free) begin
						state_d = ST_EMIT_WR;
					end
				end else if (s_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_WR: begin
				state_d = s_last ? ST_IDLE : ST_EMIT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		ram_re   = 1'b0;
		s_clr    = 1'b0;
		s_inc    = 1'b0;
		do_cmp   = 1'b0;
		do_pop   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
			end
			ST_CHECK: begin
				s_clr = 1'b1;
			end
			ST_CMP_RD: begin
				ram_re = s_en;
				s_inc  = !s_en;
			end
			ST_CMP_EV: begin
				do_cmp = 1'b1;
				s_inc  = 1'b1;
			end
			ST_EMIT_RD: begin
				ram_re = s_en && out_free;
				s_inc  = !s_en;
			end
			ST_EMIT_WR: begin
				do_pop = 1'b1;
				s_inc  = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign req_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			s_q     <= '0;
		end else begin
			state_q <= state_d;
			if (s_clr) begin
				s_q <= '0;
			end else if (s_inc) begin
				s_q <= s_last ? '0 : s_q + 1'b1;
			end
		end
	end

	// head compare pass: first enabled head is the reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_ref_q <= 1'b0;
			mm_q       <= 1'b0;
		end else if (s_clr) begin
			have_ref_q <= 1'b0;
			mm_q       <= 1'b0;
		end else if (do_cmp) begin
			if (!have_ref_q) begin
				have_ref_q <= 1'b1;
			end else if (head_evn != ref_evn_q) begin
				mm_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_cmp && !have_ref_q) begin
			ref_evn_q <= head_evn;
		end
	end

	// queue pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				rptr_q[i] <= '0;
				wptr_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (run_fire) begin
				for (int i = 0; i < SLOTS; i++) begin
					rptr_q[i] <= '0;
					wptr_q[i] <= '0;
					cnt_q[i]  <= '0;
				end
			end else if (push_ok) begin
				wptr_q[sel_idx] <= wptr_nxt;
				cnt_q[sel_idx]  <= sel_cnt + 1'b1;
			end else if (do_pop) begin
				rptr_q[sel_idx] <= rptr_nxt;
				cnt_q[sel_idx]  <= sel_cnt - 1'b1;
			end
			// mask write empties queues of sources left disabled
			if (cfg.wr) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!cfg.wdata[i]) begin
						rptr_q[i] <= '0;
						wptr_q[i] <= '0;
						cnt_q[i]  <= '0;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (drop_fire || do_pop) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drop_fire) begin
			res_q.status           <= STATUS_DROPPED;
			res_q.out_source       <= req_ch.req.source_id;
			res_q.out_event_number <= req_ch.req.event_number;
			res_q.out_payload      <= pay_drop;
			res_q.mismatch         <= 1'b0;
			res_q.last             <= 1'b1;
		end else if (do_pop) begin
			res_q.status           <= STATUS_BUILT;
			res_q.out_source       <= SRC_ID_W'(s_q);
			res_q.out_event_number <= head_evn;
			res_q.out_payload      <= pay_out;
			res_q.mismatch         <= mm_q;
			res_q.last             <= last_src;
		end
	end

	assign res_ch.valid = res_valid_q;
	assign res_ch.res   = res_q;
endmodule

// ===== sv/ensb_checker.sv =====
// port level checker for the event number sync builder, bound to the top level
module ensb_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  logic                res_valid,
	input  logic                res_ready,
	input  ensb_pkg::ensb_res_t res
);
	import ensb_pkg::*;

	// a dropped request is a single result without mismatch
	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STATUS_DROPPED) |-> res.last && !res.mismatch)
		else $error("dropped result not marked last or flagged mismatch");

	// the builder stays busy until the last sub-event of a build is out
	a_busy_mid_build: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && (res.status == STATUS_BUILT) && !res.last
		|=> !req_ready)
		else $error("request accepted in the middle of a build");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result changed while stalled");
endmodule

bind event_number_sync_builder_core ensb_checker u_ensb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_ch.valid),
	.req_ready (req_ch.ready),
	.res_valid (res_ch.valid),
	.res_ready (res_ch.ready),
	.res       (res_ch.res)
);
